### hw/rtl/dttc_pkg.sv
// Shared types and widths for the disk time-to-collision core.
// No dependencies; used by every module in hw/rtl.
`default_nettype none

package dttc_pkg;

  localparam int unsigned CW   = 49;  // c = P.P - R^2
  localparam int unsigned AW   = 33;  // a = V.V
  localparam int unsigned QW   = 42;  // -q = -(P.V)
  localparam int unsigned DW   = 84;  // discriminant quarter
  localparam int unsigned SW   = 42;  // isqrt root width
  localparam int unsigned NDW  = 43;  // denominator -q + s
  localparam int unsigned TW   = 32;  // hit time, Q16.16
  localparam int unsigned FRAC = 16;  // fraction bits of the time

  typedef enum logic [1:0] {
    ST_FUTURE = 2'd0,
    ST_TOUCH  = 2'd1,
    ST_NEVER  = 2'd2
  } hit_status_e;

  typedef struct packed {
    logic signed [23:0] first_pos_x;
    logic signed [23:0] first_pos_y;
    logic signed [15:0] first_vel_x;
    logic signed [15:0] first_vel_y;
    logic        [15:0] first_radius;
    logic signed [23:0] second_pos_x;
    logic signed [23:0] second_pos_y;
    logic signed [15:0] second_vel_x;
    logic signed [15:0] second_vel_y;
    logic        [15:0] second_radius;
  } disk_pair_t;

  typedef struct packed {
    logic [TW-1:0] hit_time;
    logic [1:0]    hit_status;
  } ttc_result_t;

  // travels beside the square root pipeline
  typedef struct packed {
    hit_status_e   status;
    logic [CW-1:0] c;
    logic [QW-1:0] negq;
  } root_side_t;

  // travels beside the divider pipeline
  typedef struct packed {
    hit_status_e status;
    logic        sat;
  } quot_side_t;

endpackage

`default_nettype wire

### hw/rtl/dttc_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
// Depends on dttc_pkg.
`default_nettype none

module dttc_sqrt_pipe (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      vld_i,
  input  wire logic [dttc_pkg::DW-1:0]   disc_i,
  input  wire dttc_pkg::root_side_t      side_i,
  output logic                           vld_o,
  output logic [dttc_pkg::SW-1:0]        root_o,
  output dttc_pkg::root_side_t           side_o
);

  localparam int unsigned SW = dttc_pkg::SW;
  localparam int unsigned RW = dttc_pkg::DW + 2;

  logic                  vld_q  [SW];
  logic [RW-1:0]         rem_q  [SW];
  logic [SW-1:0]         root_q [SW];
  dttc_pkg::root_side_t  side_q [SW];

  for (genvar i = 0; i < SW; i++) begin : g_stage
    localparam int unsigned K = SW - 1 - i;
    logic                 vld_in;
    logic [RW-1:0]        rem_in;
    logic [SW-1:0]        root_in;
    dttc_pkg::root_side_t side_in;
    logic [RW-1:0]        term;
    logic                 take;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = RW'(disc_i);
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
    assign term = (RW'(root_in) << (K + 1)) | (RW'(1) << (2 * K));
    assign take = rem_in >= term;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= take ? rem_in - term : rem_in;
      root_q[i] <= take ? (root_in | (SW'(1) << K)) : root_in;
      side_q[i] <= side_in;
    end
  end

  assign vld_o  = vld_q[SW-1];
  assign root_o = root_q[SW-1];
  assign side_o = side_q[SW-1];

endmodule

`default_nettype wire

### hw/rtl/dttc_div_pipe.sv
// Pipelined restoring divider: 32 quotient bits of (num << 16) / den.
// Depends on dttc_pkg.
`default_nettype none

module dttc_div_pipe (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      vld_i,
  input  wire logic [dttc_pkg::CW-1:0]   num_i,
  input  wire logic [dttc_pkg::NDW-1:0]  den_i,
  input  wire dttc_pkg::quot_side_t      side_i,
  output logic                           vld_o,
  output logic [dttc_pkg::TW-1:0]        quo_o,
  output dttc_pkg::quot_side_t           side_o
);

  localparam int unsigned TW   = dttc_pkg::TW;
  localparam int unsigned NDW  = dttc_pkg::NDW;
  localparam int unsigned FRAC = dttc_pkg::FRAC;
  localparam int unsigned CW   = dttc_pkg::CW;

  logic                 vld_q  [TW];
  logic [NDW-1:0]       rem_q  [TW];
  logic [TW-1:0]        bits_q [TW];
  logic [TW-1:0]        quo_q  [TW];
  logic [NDW-1:0]       den_q  [TW];
  dttc_pkg::quot_side_t side_q [TW];

  for (genvar i = 0; i < TW; i++) begin : g_stage
    logic                 vld_in;
    logic [NDW-1:0]       rem_in;
    logic [TW-1:0]        bits_in;
    logic [TW-1:0]        quo_in;
    logic [NDW-1:0]       den_in;
    dttc_pkg::quot_side_t side_in;
    logic [NDW:0]         trial;
    logic                 take;

    if (i == 0) begin : g_first
      // quotient fits 32 bits, so the top of the dividend is already below den
      assign vld_in  = vld_i;
      assign rem_in  = NDW'(num_i[CW-1:FRAC]);
      assign bits_in = {num_i[FRAC-1:0], {(TW-FRAC){1'b0}}};
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign bits_in = bits_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = {rem_in, bits_in[TW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= take ? NDW'(trial - {1'b0, den_in}) : NDW'(trial);
      bits_q[i] <= {bits_in[TW-2:0], 1'b0};
      quo_q[i]  <= {quo_in[TW-2:0], take};
      den_q[i]  <= den_in;
      side_q[i] <= side_in;
    end
  end

  assign vld_o  = vld_q[TW-1];
  assign quo_o  = quo_q[TW-1];
  assign side_o = side_q[TW-1];

endmodule

`default_nettype wire

### hw/rtl/disk_time_to_collision_core.sv
// Top level of the disk time-to-collision core.
// Depends on dttc_pkg, dttc_sqrt_pipe and dttc_div_pipe.
`default_nettype none

// Usage:
//   Input channel: drive a disk pair word on in_i and pulse start_i. busy_o
//   is tied low, so a word is taken at every edge where start_i is high;
//   one word per cycle is sustained.
//   Result channel: done_o is high for exactly one cycle with res_o valid.
//   The receiver cannot hold results off, and none is needed: nothing in the
//   pipe ever stalls.
//   Pipeline: 7 front stages (differences, products, sums, status,
//   split products of a*c and q*q, their sums, discriminant), 42 square
//   root stages (one root bit each), 1 denominator stage, 32 divider stages
//   (one quotient bit each) and the output register.
//   Status: touching now gives time 0; no motion, moving apart or no real
//   root gives never with all ones; a future contact at or past 65536 saturates.
//   Reset: clears all valid bits; words in flight are dropped, no results
//   appear until new words arrive.

module disk_time_to_collision_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire dttc_pkg::disk_pair_t in_i,
  output logic                      done_o,
  output dttc_pkg::ttc_result_t     res_o
);

  localparam int unsigned CW   = dttc_pkg::CW;
  localparam int unsigned AW   = dttc_pkg::AW;
  localparam int unsigned QW   = dttc_pkg::QW;
  localparam int unsigned DW   = dttc_pkg::DW;
  localparam int unsigned SW   = dttc_pkg::SW;
  localparam int unsigned NDW  = dttc_pkg::NDW;
  localparam int unsigned TW   = dttc_pkg::TW;
  localparam int unsigned FRAC = dttc_pkg::FRAC;
  localparam int unsigned LAT  = 8 + SW + 1 + TW + 1 - 1;

  assign busy_o = 1'b0;

  // ---- stage 1: relative position, velocity, contact distance
  logic               v1_q;
  logic signed [24:0] px_q, py_q;
  logic signed [16:0] vx_q, vy_q;
  logic        [16:0] rr_q;

  always_ff @(posedge clk_i) begin
    px_q <= {in_i.first_pos_x[23], in_i.first_pos_x}
          - {in_i.second_pos_x[23], in_i.second_pos_x};
    py_q <= {in_i.first_pos_y[23], in_i.first_pos_y}
          - {in_i.second_pos_y[23], in_i.second_pos_y};
    vx_q <= {in_i.first_vel_x[15], in_i.first_vel_x}
          - {in_i.second_vel_x[15], in_i.second_vel_x};
    vy_q <= {in_i.first_vel_y[15], in_i.first_vel_y}
          - {in_i.second_vel_y[15], in_i.second_vel_y};
    rr_q <= {1'b0, in_i.first_radius} + {1'b0, in_i.second_radius};
  end

  // ---- stage 2: products
  logic               v2_q;
  logic        [47:0] pxx_q, pyy_q;
  logic        [31:0] vxx_q, vyy_q;
  logic signed [41:0] pxv_q, pyv_q;
  logic        [33:0] rsq2_q;
  logic signed [49:0] pxx_full, pyy_full;
  logic signed [33:0] vxx_full, vyy_full;

  assign pxx_full = px_q * px_q;
  assign pyy_full = py_q * py_q;
  assign vxx_full = vx_q * vx_q;
  assign vyy_full = vy_q * vy_q;

  always_ff @(posedge clk_i) begin
    pxx_q  <= pxx_full[47:0];
    pyy_q  <= pyy_full[47:0];
    vxx_q  <= vxx_full[31:0];
    vyy_q  <= vyy_full[31:0];
    pxv_q  <= px_q * vx_q;
    pyv_q  <= py_q * vy_q;
    rsq2_q <= rr_q * rr_q;
  end

  // ---- stage 3: dot products
  logic               v3_q;
  logic [CW-1:0]      pp_q;
  logic [AW-1:0]      a3_q;
  logic signed [42:0] q_q;
  logic [33:0]        rsq3_q;

  always_ff @(posedge clk_i) begin
    pp_q   <= {1'b0, pxx_q} + {1'b0, pyy_q};
    a3_q   <= {1'b0, vxx_q} + {1'b0, vyy_q};
    q_q    <= {pxv_q[41], pxv_q} + {pyv_q[41], pyv_q};
    rsq3_q <= rsq2_q;
  end

  // ---- stage 4: early status, c and -q
  logic                  v4_q;
  dttc_pkg::hit_status_e st4_d, st4_q;
  logic [CW-1:0]         c4_q;
  logic [QW-1:0]         negq4_q;
  logic [AW-1:0]         a4_q;
  logic [42:0]           negq_full;

  assign negq_full = ~q_q + 43'd1;

  always_comb begin
    if (pp_q <= CW'(rsq3_q)) begin
      st4_d = dttc_pkg::ST_TOUCH;
    end else if (a3_q == '0 || !q_q[42]) begin
      // no relative motion, or moving apart
      st4_d = dttc_pkg::ST_NEVER;
    end else begin
      st4_d = dttc_pkg::ST_FUTURE;
    end
  end

  always_ff @(posedge clk_i) begin
    st4_q   <= st4_d;
    c4_q    <= pp_q - CW'(rsq3_q);
    negq4_q <= negq_full[QW-1:0];
    a4_q    <= a3_q;
  end

  // ---- stage 5: split products for a*c and q*q
  logic                 v5_q;
  dttc_pkg::root_side_t s5_q;
  logic [41:0]          acll_q;
  logic [40:0]          aclh_q, achl_q;
  logic [39:0]          achh_q;
  logic [41:0]          nll_q, nlh_q, nhh_q;

  always_ff @(posedge clk_i) begin
    s5_q   <= '{status: st4_q, c: c4_q, negq: negq4_q};
    acll_q <= a4_q[16:0]  * c4_q[24:0];
    aclh_q <= a4_q[16:0]  * c4_q[48:25];
    achl_q <= a4_q[32:17] * c4_q[24:0];
    achh_q <= a4_q[32:17] * c4_q[48:25];
    nll_q  <= negq4_q[20:0]  * negq4_q[20:0];
    nlh_q  <= negq4_q[20:0]  * negq4_q[41:21];
    nhh_q  <= negq4_q[41:21] * negq4_q[41:21];
  end

  // ---- stage 6: sum the partial products
  logic                 v6_q;
  dttc_pkg::root_side_t s6_q;
  logic [DW-1:0]        ac_q, nn_q;

  always_ff @(posedge clk_i) begin
    s6_q <= s5_q;
    ac_q <= DW'(acll_q) + (DW'(aclh_q) << 25) + (DW'(achl_q) << 17)
          + (DW'(achh_q) << 42);
    nn_q <= DW'(nll_q) + (DW'(nlh_q) << 22) + (DW'(nhh_q) << 42);
  end

  // ---- stage 7: discriminant; a negative one means no real root
  logic                 v7_q;
  dttc_pkg::root_side_t s7_d, s7_q;
  logic [DW-1:0]        disc7_q;

  always_comb begin
    s7_d = s6_q;
    if (s6_q.status == dttc_pkg::ST_FUTURE && nn_q < ac_q) begin
      s7_d.status = dttc_pkg::ST_NEVER;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_q    <= s7_d;
    disc7_q <= nn_q - ac_q;
  end

  // ---- square root
  logic                 vs_w;
  logic [SW-1:0]        root_w;
  dttc_pkg::root_side_t ss_w;

  dttc_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v7_q),
    .disc_i (disc7_q),
    .side_i (s7_q),
    .vld_o  (vs_w),
    .root_o (root_w),
    .side_o (ss_w)
  );

  // ---- stage 8: denominator -q + s and far-future check
  logic                 v8_q;
  logic [NDW-1:0]       den_d, den8_q;
  logic [CW-1:0]        c8_q;
  dttc_pkg::quot_side_t s8_q;
  logic [NDW+FRAC-1:0]  den_sh;

  assign den_d  = NDW'(ss_w.negq) + NDW'(root_w);
  assign den_sh = {den_d, {FRAC{1'b0}}};

  always_ff @(posedge clk_i) begin
    den8_q <= den_d;
    c8_q   <= ss_w.c;
    s8_q   <= '{status: ss_w.status, sat: ((NDW + FRAC)'(ss_w.c) >= den_sh)};
  end

  // ---- divider
  logic                 vd_w;
  logic [TW-1:0]        quo_w;
  dttc_pkg::quot_side_t sd_w;

  dttc_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v8_q),
    .num_i  (c8_q),
    .den_i  (den8_q),
    .side_i (s8_q),
    .vld_o  (vd_w),
    .quo_o  (quo_w),
    .side_o (sd_w)
  );

  // ---- output register
  logic                  done_q;
  dttc_pkg::ttc_result_t res_d, res_q;

  always_comb begin
    res_d.hit_status = sd_w.status;
    case (sd_w.status)
      dttc_pkg::ST_TOUCH:  res_d.hit_time = '0;
      dttc_pkg::ST_FUTURE: res_d.hit_time = sd_w.sat ? '1 : quo_w;
      default:             res_d.hit_time = '1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // valid bits of the front stages, stage 8 and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= vs_w;
      done_q <= vd_w;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a matching input word");

  a_touch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.hit_status == dttc_pkg::ST_TOUCH) |-> res_o.hit_time == '0)
    else $error("touching result with nonzero time");

  a_never_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.hit_status == dttc_pkg::ST_NEVER) |-> res_o.hit_time == '1)
    else $error("never result without all-ones time");

  a_front_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> $past(v1_q, 3))
    else $error("front valid bits out of step");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// Testbench for disk_time_to_collision_core: directed table plus random disk pairs.
// Depends on dttc_pkg and the core; predicts each result and checks it in order.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LATENCY    = 83;
  localparam int unsigned N_RANDOM   = 1150;
  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned N_DIRECTED = 14;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  dttc_pkg::disk_pair_t  in_i = '0;
  logic                  done_o;
  dttc_pkg::ttc_result_t res_o;

  disk_time_to_collision_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .in_i(in_i), .done_o(done_o), .res_o(res_o)
  );

  always #4 clk_i = ~clk_i;

  dttc_pkg::ttc_result_t hit_queue[$];
  int unsigned n_mismatch = 0;
  int unsigned n_words = 0;
  int unsigned n_results = 0;
  int unsigned wdog = 0;
  int unsigned status_count[3] = '{0, 0, 0};

  // floor(sqrt(d)), d below 2^86
  function automatic logic [63:0] root_floor(logic [127:0] d);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int k = 43; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if ({64'd0, t} * {64'd0, t} <= d) r = t;
    end
    return r;
  endfunction

  // Exact contact-time prediction for one disk pair.
  function automatic dttc_pkg::ttc_result_t predict_hit(dttc_pkg::disk_pair_t w);
    dttc_pkg::ttc_result_t r;
    logic signed [63:0] px, py, vx, vy, q;
    logic [63:0]        rr, pp, rsq, a, c, negq, s, den, quo, rem, t;
    logic [127:0]       ac, qq;
    px = 64'(w.first_pos_x) - 64'(w.second_pos_x);
    py = 64'(w.first_pos_y) - 64'(w.second_pos_y);
    vx = 64'(w.first_vel_x) - 64'(w.second_vel_x);
    vy = 64'(w.first_vel_y) - 64'(w.second_vel_y);
    rr = 64'(w.first_radius) + 64'(w.second_radius);
    pp = px * px + py * py;
    rsq = rr * rr;
    if (pp <= rsq) begin
      r.hit_time = '0;
      r.hit_status = dttc_pkg::ST_TOUCH;
      return r;
    end
    a = vx * vx + vy * vy;
    q = px * vx + py * vy;
    c = pp - rsq;
    r.hit_time = '1;
    r.hit_status = dttc_pkg::ST_NEVER;
    if (a == 0 || q >= 0) return r;
    negq = -q;
    ac = {64'd0, a} * {64'd0, c};
    qq = {64'd0, negq} * {64'd0, negq};
    if (ac > qq) return r;
    s = root_floor(qq - ac);
    den = negq + s;
    r.hit_status = dttc_pkg::ST_FUTURE;
    if (c >= (den << 16)) return r;
    quo = c / den;
    rem = c % den;
    t = (quo << 16) + ((rem << 16) / den);
    r.hit_time = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    return r;
  endfunction

  function automatic dttc_pkg::disk_pair_t pair_of(
      int p1x, int p1y, int v1x, int v1y, int r1,
      int p2x, int p2y, int v2x, int v2y, int r2);
    dttc_pkg::disk_pair_t w;
    w.first_pos_x = 24'(p1x); w.first_pos_y = 24'(p1y);
    w.first_vel_x = 16'(v1x); w.first_vel_y = 16'(v1y); w.first_radius = 16'(r1);
    w.second_pos_x = 24'(p2x); w.second_pos_y = 24'(p2y);
    w.second_vel_x = 16'(v2x); w.second_vel_y = 16'(v2y); w.second_radius = 16'(r2);
    return w;
  endfunction

  // Random word: mostly approaching pairs at modest scale, some with no relative motion, some full-range noise.
  function automatic dttc_pkg::disk_pair_t random_pair();
    dttc_pkg::disk_pair_t w;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (mode < 6) begin
      // closing along x with small lateral offset
      w.first_pos_x = 24'($urandom_range(0, 20000));
      w.first_pos_y = 24'(int'($urandom_range(0, 4000)) - 2000);
      w.second_pos_x = 24'(-int'($urandom_range(0, 20000)));
      w.second_pos_y = 24'(int'($urandom_range(0, 4000)) - 2000);
      w.first_vel_x = 16'(-int'($urandom_range(0, 2000)));
      w.second_vel_x = 16'($urandom_range(0, 2000));
      w.first_vel_y = 16'(int'($urandom_range(0, 200)) - 100);
      w.second_vel_y = 16'(int'($urandom_range(0, 200)) - 100);
      w.first_radius = 16'($urandom_range(0, 3000));
      w.second_radius = 16'($urandom_range(0, 3000));
    end else if (mode == 6) begin
      w.first_vel_x = w.second_vel_x;
      w.first_vel_y = w.second_vel_y;
    end
    return w;
  endfunction

  // Directed table; expected only where obvious (touch, no motion).
  dttc_pkg::disk_pair_t  dir_word[N_DIRECTED];
  logic                  dir_known[N_DIRECTED];
  dttc_pkg::ttc_result_t dir_exp[N_DIRECTED];

  initial begin
    dir_word[0]  = pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_word[1]  = pair_of(1000, 0, 5, 5, 500, 0, 0, 0, 0, 500);  // exact contact
    dir_word[2]  = pair_of(8388607, 8388607, 0, 0, 0, -8388608, -8388608, 0, 0, 0);
    dir_word[3]  = pair_of(8388607, -8388608, 32767, -32768, 65535,
                           -8388608, 8388607, -32768, 32767, 65535);
    dir_word[4]  = pair_of(-8388608, 0, 32767, 0, 65535, 8388607, 0, -32768, 0, 65535);
    dir_word[5]  = pair_of(8388607, 0, -32768, 0, 0, -8388608, 0, 32767, 0, 0);
    dir_word[6]  = pair_of(5000, 0, 100, 0, 100, 0, 0, 0, 0, 100);   // moving apart
    dir_word[7]  = pair_of(5000, 5000, -100, 0, 100, 0, 0, 0, 0, 100); // miss
    dir_word[8]  = pair_of(512, 0, -256, 0, 128, 0, 0, 0, 0, 128);   // plain hit
    dir_word[9]  = pair_of(300, 200, -256, 0, 100, 0, 0, 0, 0, 100); // grazing root
    dir_word[10] = pair_of(8388607, 0, -1, 0, 0, 0, 0, 0, 0, 0);     // far future
    dir_word[11] = pair_of(201, 0, -32768, 0, 100, 0, 0, 32767, 0, 100); // very near
    dir_word[12] = pair_of(0, 0, 0, 0, 65535, 0, 0, 0, 0, 65535);
    dir_word[13] = pair_of(-5, 7, -32768, 32767, 0, -5, 7, -32768, 32767, 0);
    for (int i = 0; i < N_DIRECTED; i++) dir_known[i] = 1'b0;
    dir_known[0] = 1'b1;
    dir_exp[0] = '{hit_time: '0, hit_status: dttc_pkg::ST_TOUCH};
    dir_known[1] = 1'b1;
    dir_exp[1] = '{hit_time: '0, hit_status: dttc_pkg::ST_TOUCH};
    dir_known[2] = 1'b1;
    dir_exp[2] = '{hit_time: '1, hit_status: dttc_pkg::ST_NEVER};
    dir_known[12] = 1'b1;
    dir_exp[12] = '{hit_time: '0, hit_status: dttc_pkg::ST_TOUCH};
  end

  // Result checker; the receiver cannot stall, so every strobe is consumed.
  always @(posedge clk_i) begin
    dttc_pkg::ttc_result_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (hit_queue.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result word %h", res_o);
      end else begin
        want = hit_queue.pop_front();
        if (res_o.hit_status < 3) status_count[res_o.hit_status]++;
        if (res_o.hit_time !== want.hit_time || res_o.hit_status !== want.hit_status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: time exp %h got %h, status exp %0d got %0d",
                     want.hit_time, res_o.hit_time, want.hit_status, res_o.hit_status);
        end
      end
    end
  end

  // Watchdog on cycles where nothing is accepted on either side.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("[disk_time_to_collision_core] ERROR");
      $finish;
    end
  end

  // Drive one word at the falling edge and wait until it is taken.
  task automatic send_word(dttc_pkg::disk_pair_t w, dttc_pkg::ttc_result_t exp_word,
                           logic known);
    in_i <= w;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    hit_queue.push_back(known ? exp_word : predict_hit(w));
    n_words++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  initial begin
    int unsigned burst;
    int unsigned sent;
    int unsigned tail;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(dir_word[i], dir_exp[i], dir_known[i]);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
    end
    idle_gap(1);
    // drain fully before the random part
    while (hit_queue.size() != 0) @(negedge clk_i);

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        send_word(random_pair(), '0, 1'b0);
        sent++;
      end
      if (sent == N_RANDOM / 2) begin
        idle_gap(1);
        while (hit_queue.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    start_i <= 1'b0;

    tail = 0;
    while (hit_queue.size() != 0 && tail < 10 * LATENCY) begin
      @(negedge clk_i);
      tail++;
    end
    repeat (LATENCY + 5) @(negedge clk_i);

    $display("sent %0d words, %0d results: future %0d, touching %0d, never %0d",
             n_words, n_results, status_count[0], status_count[1], status_count[2]);
    if (n_mismatch == 0 && hit_queue.size() == 0) begin
      $display("[disk_time_to_collision_core] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, hit_queue.size());
      $display("[disk_time_to_collision_core] ERROR");
    end
    $finish;
  end

endmodule
